FILE: rtl/q13_matmul_four_row_mac_defines.svh
// Assertion macros for the Q13 four-row multiply-accumulate block.
// Used by the checker; depends on clk and rst_n being visible at the point of use.
`ifndef Q13_MATMUL_FOUR_ROW_MAC_DEFINES_SVH
`define Q13_MATMUL_FOUR_ROW_MAC_DEFINES_SVH

// Checked only while the block is out of reset.
`define Q13MM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define Q13MM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/q13mm_pkg.sv
// Shared types, constants and arithmetic helpers of the Q13 multiply-accumulate block.
// Used by the top level, the fp16 packing stage and the checker.
`timescale 1ns / 1ps

package q13mm_pkg;

    localparam int ROWS      = 4;
    localparam int FRAC_BITS = 13;
    localparam int HALF_W    = 16;
    localparam int Q_W       = 16;
    localparam int ACC_W     = 32;
    localparam int M_W       = ACC_W + 1;
    localparam int LEN_W     = 6;
    localparam int F32_SIG   = 24;
    localparam int HALF_SIG  = 11;
    localparam int EXP_MAX   = 31;

    localparam int QSHIFT    = 25 - FRAC_BITS;
    localparam int QSAT_EX   = QSHIFT + 6;
    localparam int QT_W      = HALF_SIG + QSAT_EX;
    localparam int VAL_W     = QT_W - QSHIFT + 1;

    localparam int NORM_LEN  = 2 * FRAC_BITS - 13;
    localparam int EXP_OFS   = 2 * FRAC_BITS - 14;
    localparam int SUB_SH    = 2 * FRAC_BITS - 24;
    localparam int SUB_RSH   = (SUB_SH > 0) ? SUB_SH : 0;
    localparam int SUB_LSH   = (SUB_SH < 0) ? -SUB_SH : 0;

    localparam logic signed [Q_W-1:0] Q_MAX    = 16'sh7FFF;
    localparam logic signed [Q_W-1:0] Q_MIN    = 16'sh8000;
    localparam logic [HALF_W-2:0]     HALF_INF = 15'h7C00;
    localparam logic [4:0]            EXP_SPECIAL = 5'h1F;

    typedef struct packed {
        logic [HALF_W-1:0] left_row0;
        logic [HALF_W-1:0] left_row1;
        logic [HALF_W-1:0] left_row2;
        logic [HALF_W-1:0] left_row3;
        logic [HALF_W-1:0] right_value;
        logic              last_step;
    } step_t;

    typedef struct packed {
        logic [HALF_W-1:0] sum_row0;
        logic [HALF_W-1:0] sum_row1;
        logic [HALF_W-1:0] sum_row2;
        logic [HALF_W-1:0] sum_row3;
    } result_t;

    // fp16 pattern to signed Q value, rounded half away from zero and saturated.
    function automatic logic signed [Q_W-1:0] quantize(input logic [HALF_W-1:0] h);
        logic                    neg;
        logic [4:0]              ex;
        logic [9:0]              fr;
        logic [HALF_SIG-1:0]     mag;
        logic [4:0]              sh_ex;
        logic [QT_W-1:0]         t;
        logic [VAL_W-1:0]        val;
        logic signed [Q_W-1:0]   res;
        neg   = h[HALF_W-1];
        ex    = h[14:10];
        fr    = h[9:0];
        mag   = {(ex != 5'd0), fr};
        sh_ex = (ex == 5'd0) ? 5'd1 : ex;
        t     = QT_W'(mag) << sh_ex;
        val   = VAL_W'(t >> QSHIFT) + VAL_W'(t[QSHIFT-1]);
        if (ex == EXP_SPECIAL)
        begin
            res = (fr != 10'd0) ? '0 : (neg ? Q_MIN : Q_MAX);
        end
        else if (ex >= 5'(QSAT_EX))
        begin
            res = neg ? Q_MIN : Q_MAX;
        end
        else if (neg)
        begin
            res = (val > VAL_W'(32768)) ? Q_MIN : $signed(~val[Q_W-1:0] + Q_W'(1));
        end
        else
        begin
            res = (val > VAL_W'(32767)) ? Q_MAX : $signed(val[Q_W-1:0]);
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] bit_len(input logic [M_W-1:0] m);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < M_W; i++)
        begin
            if (m[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

    // Right shift with round to nearest even; a shift of zero passes the value through.
    function automatic logic [M_W-1:0] rne_shift(input logic [M_W-1:0] m,
                                                 input logic [LEN_W-1:0] sh);
        logic [M_W-1:0] q;
        logic [M_W-1:0] mask;
        logic [M_W-1:0] rem;
        logic [M_W-1:0] half;
        logic           inc;
        q    = m >> sh;
        mask = (M_W'(1) << sh) - M_W'(1);
        rem  = m & mask;
        half = (sh == '0) ? '0 : (M_W'(1) << (sh - LEN_W'(1)));
        inc  = (sh != '0) && ((rem > half) || ((rem == half) && q[0]));
        return q + M_W'(inc);
    endfunction

endpackage

FILE: rtl/q13mm_fp16_pack.sv
// Converts finished accumulator values to fp16 over three registered stages.
// Depends on q13mm_pkg for widths, the result type and the rounding helpers.
`timescale 1ns / 1ps

module q13mm_fp16_pack
    import q13mm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sum_valid,
    output logic             sum_ready,
    input  logic [ACC_W-1:0] sum [ROWS],
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    logic             n_v_reg;
    logic             n_sign_reg [ROWS];
    logic [M_W-1:0]   n_mag_reg  [ROWS];
    logic [LEN_W-1:0] n_len_reg  [ROWS];

    logic             r_v_reg;
    logic             r_sign_reg [ROWS];
    logic [M_W-1:0]   r_mag_reg  [ROWS];
    logic [LEN_W-1:0] r_len_reg  [ROWS];

    logic             result_valid_reg;
    result_t          result_reg;

    logic             out_free;
    logic             r_free;
    logic             n_free;

    logic [M_W-1:0]   n_mag_next [ROWS];
    logic [LEN_W-1:0] k_sh       [ROWS];
    logic [M_W-1:0]   rr         [ROWS];
    logic [M_W-1:0]   r_mag_next [ROWS];
    logic [LEN_W-1:0] r_len_next [ROWS];

    logic             normal     [ROWS];
    logic [LEN_W-1:0] nrm_rsh    [ROWS];
    logic [LEN_W-1:0] nrm_lsh    [ROWS];
    logic [M_W-1:0]   rn         [ROWS];
    logic [M_W-1:0]   rn_adj     [ROWS];
    logic [M_W-1:0]   rs         [ROWS];
    logic [7:0]       fe         [ROWS];
    logic [HALF_W-1:0] half_val  [ROWS];
    result_t          result_next;

    assign out_free  = !result_valid_reg || result_ready;
    assign r_free    = !r_v_reg || out_free;
    assign n_free    = !n_v_reg || r_free;
    assign sum_ready = n_free;

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            n_mag_next[i] = sum[i][ACC_W-1] ? M_W'(ACC_W'(~sum[i] + ACC_W'(1))) :
                            M_W'(sum[i]);

            k_sh[i]       = (n_len_reg[i] > LEN_W'(F32_SIG)) ?
                            (n_len_reg[i] - LEN_W'(F32_SIG)) : '0;
            rr[i]         = rne_shift(n_mag_reg[i], k_sh[i]);
            r_mag_next[i] = rr[i] << k_sh[i];
            r_len_next[i] = n_len_reg[i] + LEN_W'(rr[i][F32_SIG]);

            normal[i]  = r_len_reg[i] >= LEN_W'(NORM_LEN);
            nrm_rsh[i] = (r_len_reg[i] >= LEN_W'(HALF_SIG)) ?
                         (r_len_reg[i] - LEN_W'(HALF_SIG)) : '0;
            nrm_lsh[i] = (r_len_reg[i] < LEN_W'(HALF_SIG)) ?
                         (LEN_W'(HALF_SIG) - r_len_reg[i]) : '0;
            rn[i]      = rne_shift(r_mag_reg[i], nrm_rsh[i]) << nrm_lsh[i];
            rn_adj[i]  = rn[i][HALF_SIG] ? (rn[i] >> 1) : rn[i];
            fe[i]      = 8'(r_len_reg[i]) + 8'(rn[i][HALF_SIG]) - 8'(EXP_OFS);
            rs[i]      = rne_shift(r_mag_reg[i], LEN_W'(SUB_RSH)) << SUB_LSH;

            if (!normal[i])
            begin
                half_val[i] = {r_sign_reg[i], rs[i][HALF_W-2:0]};
            end
            else if (fe[i] >= 8'(EXP_MAX))
            begin
                half_val[i] = {r_sign_reg[i], HALF_INF};
            end
            else
            begin
                half_val[i] = {r_sign_reg[i], fe[i][4:0], rn_adj[i][9:0]};
            end
        end
        result_next.sum_row0 = half_val[0];
        result_next.sum_row1 = half_val[1];
        result_next.sum_row2 = half_val[2];
        result_next.sum_row3 = half_val[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_v_reg          <= 1'b0;
            r_v_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (n_free)
            begin
                n_v_reg <= sum_valid;
            end
            if (r_free)
            begin
                r_v_reg <= n_v_reg;
            end
            if (out_free)
            begin
                result_valid_reg <= r_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            if (n_free)
            begin
                n_sign_reg[i] <= sum[i][ACC_W-1];
                n_mag_reg[i]  <= n_mag_next[i];
                n_len_reg[i]  <= bit_len(n_mag_next[i]);
            end
            if (r_free)
            begin
                r_sign_reg[i] <= n_sign_reg[i];
                r_mag_reg[i]  <= r_mag_next[i];
                r_len_reg[i]  <= r_len_next[i];
            end
        end
        if (out_free)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/q13_matmul_four_row_mac.sv
// Throughput: one step per cycle while the output is not stalled; quantize, multiply,
// accumulate and the three fp16 stages are each one register deep, and the result register
// parts the output side.
// Reset clears the four accumulators and every stage valid; payload is not reset.
// Depends on q13mm_pkg and q13mm_fp16_pack.
`timescale 1ns / 1ps

module q13_matmul_four_row_mac
    import q13mm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_valid,
    output logic    step_ready,
    input  step_t   step,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic                   step_v_reg;
    step_t                  step_reg;

    logic                   q_v_reg;
    logic                   q_last_reg;
    logic signed [Q_W-1:0]  lq_reg [ROWS];
    logic signed [Q_W-1:0]  rq_reg;

    logic                   p_v_reg;
    logic                   p_last_reg;
    logic signed [ACC_W-1:0] prod_reg [ROWS];

    logic [ACC_W-1:0]       acc_reg  [ROWS];
    logic [ACC_W-1:0]       acc_next [ROWS];

    logic                   sum_v_reg;
    logic [ACC_W-1:0]       sum_reg [ROWS];

    logic [HALF_W-1:0]      left_val [ROWS];
    logic                   pack_ready;
    logic                   sum_free;
    logic                   p_free;
    logic                   q_free;
    logic                   s_free;

    assign sum_free   = !sum_v_reg || pack_ready;
    assign p_free     = !p_v_reg || !p_last_reg || sum_free;
    assign q_free     = !q_v_reg || p_free;
    assign s_free     = !step_v_reg || q_free;
    assign step_ready = s_free;

    always_comb
    begin
        left_val[0] = step_reg.left_row0;
        left_val[1] = step_reg.left_row1;
        left_val[2] = step_reg.left_row2;
        left_val[3] = step_reg.left_row3;
        for (int i = 0; i < ROWS; i++)
        begin
            acc_next[i] = acc_reg[i] + $unsigned(prod_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_v_reg <= 1'b0;
            q_v_reg    <= 1'b0;
            p_v_reg    <= 1'b0;
            sum_v_reg  <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_free)
            begin
                step_v_reg <= step_valid;
            end
            if (q_free)
            begin
                q_v_reg <= step_v_reg;
            end
            if (p_free)
            begin
                p_v_reg <= q_v_reg;
            end
            if (sum_free)
            begin
                sum_v_reg <= p_v_reg && p_last_reg;
            end
            if (p_v_reg && p_free)
            begin
                for (int i = 0; i < ROWS; i++)
                begin
                    acc_reg[i] <= p_last_reg ? '0 : acc_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_free)
        begin
            step_reg <= step;
        end
        if (q_free)
        begin
            q_last_reg <= step_reg.last_step;
            rq_reg     <= quantize(step_reg.right_value);
            for (int i = 0; i < ROWS; i++)
            begin
                lq_reg[i] <= quantize(left_val[i]);
            end
        end
        if (p_free)
        begin
            p_last_reg <= q_last_reg;
            for (int i = 0; i < ROWS; i++)
            begin
                prod_reg[i] <= lq_reg[i] * rq_reg;
            end
        end
        if (sum_free)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                sum_reg[i] <= acc_next[i];
            end
        end
    end

    q13mm_fp16_pack u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_v_reg),
        .sum_ready    (pack_ready),
        .sum          (sum_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: rtl/q13mm_checker.sv
// Port-level checker for the Q13 multiply-accumulate block, bound to the top level.
// Depends on q13mm_pkg and the assertion macros in q13_matmul_four_row_mac_defines.svh.
`timescale 1ns / 1ps
`include "q13_matmul_four_row_mac_defines.svh"

module q13mm_checker
    import q13mm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    step_valid,
    input logic    step_ready,
    input step_t   step,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    `Q13MM_ASSERT_RST(a_no_result_in_reset, !rst_n |=> !result_valid, "result valid during reset")

    `Q13MM_ASSERT(a_result_holds, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")

    `Q13MM_ASSERT(a_stall_from_output, !step_ready |-> result_valid && !result_ready, "input stalled without output back pressure")

    `Q13MM_ASSERT(a_latency, step_valid && step_ready && step.last_step ##1 result_ready ##1 result_ready ##1 result_ready ##1 result_ready ##1 result_ready ##1 result_ready |=> result_valid, "last step did not produce a result in time")

endmodule

bind q13_matmul_four_row_mac q13mm_checker u_checker (.*);
